// File: sv/sna_pkg.sv
// Shared types and codes for the storage node allocator.
package sna_pkg;

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_USER  = 2'd1;
    localparam logic [1:0] CMD_BLOCK = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int unsigned BLOCK_W   = 21;
    localparam logic [BLOCK_W-1:0] BLOCK_RESET = 21'd1024;
    localparam logic [15:0] USERS_MAX = 16'hFFFF;

    // One node table entry
    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [15:0] users;
        logic [39:0] free;
    } entry_t;

endpackage

// File: sv/storage_node_allocator.sv
// Storage node allocator: node table, scan sequencer and result registers.
//
// Usage: drive command and the add_* fields with start high while busy is
// low; the request is taken at that edge and busy rises while a scan runs.
// add appends a node (or reports a duplicate), assign-user picks the node
// with fewest users, assign-block picks the node with most free bytes; ties
// go to the lowest index. One result appears for exactly one cycle with
// result_valid high. Command 3 is dropped with no result.
// An assign on an empty table leaves busy low and answers in the cycle after
// it is taken. Otherwise the sequencer reads the table one entry per cycle
// through a single memory read port and one shared compare unit, and busy
// falls in the cycle that shows the result.
// block_bytes is written over the cfg channel (cfg_ready is always high) and
// should only change while busy is low.
// Reset clears the node count and block_bytes returns to 1024; table
// contents are not cleared, only entries below the count are ever read.
// The receiver cannot stall: results are shown once and not held.
module storage_node_allocator
    import sna_pkg::*;
#(
    parameter int unsigned MAX_NODES = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [31:0]        add_address,
    input  logic [15:0]        add_port,
    input  logic [39:0]        add_capacity,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BLOCK_W-1:0] cfg_block_bytes,
    output logic               result_valid,
    output logic [1:0]         status,
    output logic [3:0]         chosen_index,
    output logic [31:0]        chosen_address,
    output logic [15:0]        chosen_port,
    output logic [15:0]        chosen_users,
    output logic [39:0]        chosen_free
);

    localparam int unsigned IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Node table
    entry_t mem [MAX_NODES];

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BLOCK_W-1:0] block_reg, block_next;
    logic [1:0]         cmd_reg, cmd_next;
    entry_t             req_reg, req_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               found_reg, found_next;
    entry_t             best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    entry_t             rd_reg;

    logic               res_valid_reg, res_valid_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    entry_t             res_entry_reg, res_entry_next;

    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_data;
    entry_t             upd;
    logic               better;
    logic [IDX_W+3:0]   idx_ext;

    // Table memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[issue_reg[IDX_W-1:0]];
        end
    end

    // Shared compare unit: judges the entry read last cycle
    always_comb
    begin
        better = 1'b0;
        unique case (cmd_reg)
            CMD_ADD:   better = !found_reg && (rd_reg.address == req_reg.address)
                                && (rd_reg.port == req_reg.port);
            CMD_USER:  better = !found_reg || (rd_reg.users < best_reg.users);
            CMD_BLOCK: better = !found_reg || (rd_reg.free > best_reg.free);
            default:   better = 1'b0;
        endcase
    end

    // Update of the chosen entry
    always_comb
    begin
        upd = best_reg;
        if (cmd_reg == CMD_USER)
        begin
            if (best_reg.users != USERS_MAX)
            begin
                upd.users = best_reg.users + 16'd1;
            end
        end
        else
        begin
            if (best_reg.free > {19'd0, block_reg})
            begin
                upd.free = best_reg.free - {19'd0, block_reg};
            end
            else
            begin
                upd.free = '0;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        block_next      = block_reg;
        cmd_next        = cmd_reg;
        req_next        = req_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_entry_next  = res_entry_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = best_idx_reg;
        wr_data         = upd;

        if (cfg_valid)
        begin
            block_next = cfg_block_bytes;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && command != CMD_NONE)
                begin
                    if (command != CMD_ADD && count_reg == '0)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_EMPTY;
                        res_idx_next    = '0;
                        res_entry_next  = '0;
                    end
                    else
                    begin
                        cmd_next          = command;
                        req_next.address  = add_address;
                        req_next.port     = add_port;
                        req_next.users    = '0;
                        req_next.free     = add_capacity;
                        issue_next        = '0;
                        pend_next         = 1'b0;
                        found_next        = 1'b0;
                        state_next        = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // issue the next read
                if (issue_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // judge the entry that arrived
                if (pend_reg && better)
                begin
                    found_next    = 1'b1;
                    best_next     = rd_reg;
                    best_idx_next = pend_idx_reg;
                end
                if (issue_reg >= count_reg && !pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (cmd_reg == CMD_ADD)
                begin
                    if (found_reg)
                    begin
                        res_status_next = ST_DUP;
                        res_idx_next    = best_idx_reg;
                        res_entry_next  = best_reg;
                    end
                    else if (count_reg >= CNT_MAX)
                    begin
                        res_status_next = ST_FULL;
                        res_idx_next    = '0;
                        res_entry_next  = '0;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        wr_idx          = count_reg[IDX_W-1:0];
                        wr_data         = req_reg;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_DONE;
                        res_idx_next    = count_reg[IDX_W-1:0];
                        res_entry_next  = req_reg;
                    end
                end
                else
                begin
                    wr_en           = 1'b1;
                    res_status_next = ST_DONE;
                    res_idx_next    = best_idx_reg;
                    res_entry_next  = upd;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            block_reg     <= BLOCK_RESET;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            issue_reg     <= '0;
            cmd_reg       <= CMD_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            block_reg     <= block_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            issue_reg     <= issue_next;
            cmd_reg       <= cmd_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        pend_idx_reg   <= pend_idx_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_entry_reg  <= res_entry_next;
    end

    // Ports
    assign idx_ext        = {4'd0, res_idx_reg};
    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign result_valid   = res_valid_reg;
    assign status         = res_status_reg;
    assign chosen_index   = idx_ext[3:0];
    assign chosen_address = res_entry_reg.address;
    assign chosen_port    = res_entry_reg.port;
    assign chosen_users   = res_entry_reg.users;
    assign chosen_free    = res_entry_reg.free;

endmodule
